// ===== rtl/core/quaternion_axis_angle_rotate_macros.svh =====
`ifndef QUATERNION_AXIS_ANGLE_ROTATE_MACROS_SVH
`define QUATERNION_AXIS_ANGLE_ROTATE_MACROS_SVH

// same-cycle implication, quiet during reset
`define QAAR_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define QAAR_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/qaar_pkg.sv =====
package qaar_pkg;

  // taylor series: terms after the first, and register stages per term
  localparam int TAY_STEPS = 10;
  localparam int TAY_LAT   = 3;
  // result bits of the square root and of the axis divider
  localparam int SQ_BITS   = 30;
  localparam int DIV_BITS  = 30;

  // per-term divisors: (2k)(2k+1) for sine, (2k-1)(2k) for cosine
  localparam logic [8:0] SIN_DIV [TAY_STEPS] = '{
    9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342, 9'd420
  };
  localparam logic [8:0] COS_DIV [TAY_STEPS] = '{
    9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306, 9'd380
  };

  // floor(2^32 / d), the quotient estimate is then low by at most one
  localparam logic [31:0] SIN_RECIP [TAY_STEPS] = '{
    32'(64'h1_0000_0000 / 64'd6),   32'(64'h1_0000_0000 / 64'd20),
    32'(64'h1_0000_0000 / 64'd42),  32'(64'h1_0000_0000 / 64'd72),
    32'(64'h1_0000_0000 / 64'd110), 32'(64'h1_0000_0000 / 64'd156),
    32'(64'h1_0000_0000 / 64'd210), 32'(64'h1_0000_0000 / 64'd272),
    32'(64'h1_0000_0000 / 64'd342), 32'(64'h1_0000_0000 / 64'd420)
  };
  localparam logic [31:0] COS_RECIP [TAY_STEPS] = '{
    32'(64'h1_0000_0000 / 64'd2),   32'(64'h1_0000_0000 / 64'd12),
    32'(64'h1_0000_0000 / 64'd30),  32'(64'h1_0000_0000 / 64'd56),
    32'(64'h1_0000_0000 / 64'd90),  32'(64'h1_0000_0000 / 64'd132),
    32'(64'h1_0000_0000 / 64'd182), 32'(64'h1_0000_0000 / 64'd240),
    32'(64'h1_0000_0000 / 64'd306), 32'(64'h1_0000_0000 / 64'd380)
  };

  // taylor cell link: squared half angle, current term, running sum (q28)
  typedef struct packed {
    logic signed [31:0] t2;
    logic signed [30:0] term;
    logic signed [31:0] acc;
  } tay_t;

  // square root cell link: radicand bits still to consume, remainder, root
  typedef struct packed {
    logic [59:0]         rad;
    logic [30:0]         rem;
    logic [SQ_BITS-1:0]  root;
  } sq_t;

  // divider cell link: dividend bits still to consume, remainder, quotient, divisor
  typedef struct packed {
    logic [DIV_BITS-1:0] num;
    logic [DIV_BITS-1:0] rem;
    logic [DIV_BITS-1:0] quo;
    logic [DIV_BITS-1:0] den;
  } dv_t;

endpackage

// ===== rtl/core/qaar_tay_cell.sv =====
module qaar_tay_cell (
  input  logic           clk,
  input  logic           en,
  input  logic [8:0]     div_i,
  input  logic [31:0]    recip_i,
  input  qaar_pkg::tay_t tay_i,
  output qaar_pkg::tay_t tay_o
);
  import qaar_pkg::*;

  // stage 1: term * t2
  logic signed [62:0] prod_r;
  logic signed [31:0] t2_a_r;
  logic signed [31:0] acc_a_r;
  // stage 2: magnitude times reciprocal
  logic signed [34:0] fl;
  logic [31:0]        mag_nxt;
  logic [63:0]        mq_r;
  logic [31:0]        mag_r;
  logic               neg_r;
  logic signed [31:0] t2_b_r;
  logic signed [31:0] acc_b_r;
  // stage 3: correct quotient, negate, accumulate
  logic [31:0]        q0;
  logic [31:0]        qd;
  logic [31:0]        rmd;
  logic [31:0]        qt;
  logic signed [30:0] term_nxt;
  logic signed [31:0] acc_nxt;
  tay_t               tay_r;

  assign fl      = 35'(prod_r >>> 28);
  assign mag_nxt = fl[34] ? 32'(-fl) : 32'(fl);

  assign q0  = mq_r[63:32];
  assign qd  = 32'(41'(q0) * 41'(div_i));
  assign rmd = mag_r - qd;
  assign qt  = (rmd >= 32'(div_i)) ? q0 + 32'd1 : q0;
  // next term is minus the truncated quotient
  assign term_nxt = neg_r ? signed'(qt[30:0]) : -signed'(qt[30:0]);
  assign acc_nxt  = acc_b_r + 32'(term_nxt);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= 63'(tay_i.term) * 63'(tay_i.t2);
      t2_a_r  <= tay_i.t2;
      acc_a_r <= tay_i.acc;

      mq_r    <= 64'(mag_nxt) * 64'(recip_i);
      mag_r   <= mag_nxt;
      neg_r   <= fl[34];
      t2_b_r  <= t2_a_r;
      acc_b_r <= acc_a_r;

      tay_r.t2   <= t2_b_r;
      tay_r.term <= term_nxt;
      tay_r.acc  <= acc_nxt;
    end
  end

  assign tay_o = tay_r;

endmodule

// ===== rtl/core/qaar_sqrt_cell.sv =====
module qaar_sqrt_cell (
  input  logic          clk,
  input  logic          en,
  input  qaar_pkg::sq_t sq_i,
  output qaar_pkg::sq_t sq_o
);
  import qaar_pkg::*;

  logic [32:0]        rem_sh;
  logic [32:0]        trial;
  logic               ge;
  logic [32:0]        rem_dif;
  sq_t                sq_r;

  // bring down two radicand bits, try root*4+1
  assign rem_sh  = {sq_i.rem, sq_i.rad[59:58]};
  assign trial   = {1'b0, sq_i.root, 2'b01};
  assign ge      = (rem_sh >= trial);
  assign rem_dif = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r.rad  <= {sq_i.rad[57:0], 2'b00};
      sq_r.rem  <= ge ? rem_dif[30:0] : rem_sh[30:0];
      sq_r.root <= {sq_i.root[SQ_BITS-2:0], ge};
    end
  end

  assign sq_o = sq_r;

endmodule

// ===== rtl/core/qaar_div_cell.sv =====
module qaar_div_cell (
  input  logic          clk,
  input  logic          en,
  input  qaar_pkg::dv_t dv_i,
  output qaar_pkg::dv_t dv_o
);
  import qaar_pkg::*;

  logic [DIV_BITS:0] rem_sh;
  logic [DIV_BITS:0] rem_dif;
  logic              ge;
  dv_t               dv_r;

  // restoring step, one quotient bit
  assign rem_sh  = {dv_i.rem, dv_i.num[DIV_BITS-1]};
  assign rem_dif = rem_sh - {1'b0, dv_i.den};
  assign ge      = (rem_sh >= {1'b0, dv_i.den});

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r.num <= {dv_i.num[DIV_BITS-2:0], 1'b0};
      dv_r.rem <= ge ? rem_dif[DIV_BITS-1:0] : rem_sh[DIV_BITS-1:0];
      dv_r.quo <= {dv_i.quo[DIV_BITS-2:0], ge};
      dv_r.den <= dv_i.den;
    end
  end

  assign dv_o = dv_r;

endmodule

// ===== rtl/core/quaternion_axis_angle_rotate.sv =====
// channel  | dir | bits                 | contents
// in_*     | in  | tdata 128            | point_x,y,z,w, axis_x,y,z, angle (16 each)
// out_*    | out | tdata 80, tuser 1    | rot_x,y,z,w (18 each), 8 zero bits; axis_zero
//
// one beat accepted per cycle whenever the pipe advances
// pipe depth is set by the 30-stage square root and 30-stage divider cell rows in series
// taylor sine and cosine rows (10 cells of 3 stages) run beside the square root row
// the whole pipe advances together; it keeps taking beats while out is stalled
// as long as the last pipe stage is empty, and freezes only when that stage is full
// rst_n (synchronous) clears the valid bits and the output valid only
`include "quaternion_axis_angle_rotate_macros.svh"

module quaternion_axis_angle_rotate (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // point_x, point_y, point_z, point_w, axis_x, axis_y, axis_z, angle
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // rot_x, rot_y, rot_z, rot_w, 8 zero bits
  output logic [79:0]  out_tdata,
  // axis_zero
  output logic         out_tuser
);
  import qaar_pkg::*;

  // input stage, square root row, two setup stages, divider row, four tail stages
  localparam int NSTG = 1 + SQ_BITS + 2 + DIV_BITS + 4;

  typedef struct packed {
    logic [3:0][15:0] p;
    logic [2:0][15:0] a;
    logic             zero;
  } pay_a_t;

  typedef struct packed {
    logic [3:0][15:0]   p;
    logic signed [31:0] c;
    logic [2:0]         neg;
    logic               zero;
  } pay_b_t;

  logic               en;
  logic [NSTG-1:0]    v_r;

  // input unpack
  logic [3:0][15:0]   p_in;
  logic [2:0][15:0]   a_in;
  logic signed [15:0] ang_in;
  logic signed [31:0] sq_ax, sq_ay, sq_az;
  logic signed [31:0] t2_nxt;
  logic [31:0]        l2_nxt;

  // stage 1
  logic [31:0]        l2_r;
  logic signed [31:0] t2_r;
  logic signed [30:0] theta_r;
  pay_a_t             pay1_r;

  // cell rows
  tay_t               sin_bus [TAY_STEPS+1];
  tay_t               cos_bus [TAY_STEPS+1];
  sq_t                sq_bus  [SQ_BITS+1];
  pay_a_t             dla_r   [SQ_BITS];

  // products a_i * sin
  logic signed [47:0] as32_r [3];
  logic signed [31:0] c32_r;
  logic [SQ_BITS-1:0] len32_r;
  logic [3:0][15:0]   p32_r;
  logic               zero32_r;

  // divider setup and row
  logic [43:0]        as_mag [3];
  dv_t                dv33_r [3];
  dv_t                dv_bus [3][DIV_BITS+1];
  pay_b_t             pay33_r;
  pay_b_t             dlb_r [DIV_BITS];

  // rotation quaternion q
  logic signed [30:0] q64_r [4];
  logic [3:0][15:0]   p64_r;
  logic               zero64_r;

  // first hamilton product q*p
  logic signed [46:0] m65_r [4][4];
  logic signed [30:0] q65_r [4];
  logic [3:0][15:0]   p65_r;
  logic               zero65_r;
  logic signed [49:0] o66 [4];
  logic signed [31:0] r66_r [4];
  logic signed [30:0] qc66_r [4];
  logic [3:0][15:0]   p66_r;
  logic               zero66_r;

  // second hamilton product r*conj(q)
  logic signed [62:0] n67_r [4][4];
  logic [3:0][15:0]   p67_r;
  logic               zero67_r;
  logic signed [64:0] w_sum [4];
  logic signed [22:0] w_rnd [4];
  logic [17:0]        rot_nxt [4];

  // output register
  logic               out_tvalid_r;
  logic [3:0][17:0]   rot_r;
  logic               out_zero_r;
  logic               byp_fit;

  // pipe moves when the last stage is empty or the output slot frees up
  assign en        = !v_r[NSTG-1] || !out_tvalid_r || out_tready;
  assign in_tready = en;

  always_comb begin
    for (int j = 0; j < 4; j++) p_in[j] = in_tdata[16*j +: 16];
    for (int i = 0; i < 3; i++) a_in[i] = in_tdata[64+16*i +: 16];
  end
  assign ang_in = signed'(in_tdata[127:112]);

  assign sq_ax  = 32'(signed'(a_in[0])) * 32'(signed'(a_in[0]));
  assign sq_ay  = 32'(signed'(a_in[1])) * 32'(signed'(a_in[1]));
  assign sq_az  = 32'(signed'(a_in[2])) * 32'(signed'(a_in[2]));
  // squared length of the axis, q28, at most 3 * 2^30
  assign l2_nxt = unsigned'(sq_ax) + unsigned'(sq_ay) + unsigned'(sq_az);
  // half angle is angle * 2^14 in q28, so its square over 2^28 is exactly angle^2
  assign t2_nxt = 32'(ang_in) * 32'(ang_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_tvalid};
    end
  end

  // stage 1: axis length squared, angle squared
  always_ff @(posedge clk) begin
    if (en) begin
      l2_r        <= l2_nxt;
      t2_r        <= t2_nxt;
      theta_r     <= signed'({ang_in[15], ang_in, 14'b0});
      pay1_r.p    <= p_in;
      pay1_r.a    <= a_in;
      pay1_r.zero <= (a_in == '0);
    end
  end

  // sine and cosine rows, one taylor term per cell
  assign sin_bus[0] = '{t2: t2_r, term: theta_r, acc: 32'(theta_r)};
  assign cos_bus[0] = '{t2: t2_r, term: 31'sd268435456, acc: 32'sd268435456};

  for (genvar k = 0; k < TAY_STEPS; k++) begin : g_tay
    qaar_tay_cell u_sin (
      .clk     (clk),
      .en      (en),
      .div_i   (SIN_DIV[k]),
      .recip_i (SIN_RECIP[k]),
      .tay_i   (sin_bus[k]),
      .tay_o   (sin_bus[k+1])
    );
    qaar_tay_cell u_cos (
      .clk     (clk),
      .en      (en),
      .div_i   (COS_DIV[k]),
      .recip_i (COS_RECIP[k]),
      .tay_i   (cos_bus[k]),
      .tay_o   (cos_bus[k+1])
    );
  end

  // square root of l2 * 2^28, one root bit per cell
  assign sq_bus[0] = '{rad: {l2_r, 28'b0}, rem: '0, root: '0};

  for (genvar k = 0; k < SQ_BITS; k++) begin : g_sq
    qaar_sqrt_cell u_sq (
      .clk  (clk),
      .en   (en),
      .sq_i (sq_bus[k]),
      .sq_o (sq_bus[k+1])
    );
  end

  // payload rides beside the rows
  always_ff @(posedge clk) begin
    if (en) begin
      dla_r[0] <= pay1_r;
      for (int i = 1; i < SQ_BITS; i++) dla_r[i] <= dla_r[i-1];
    end
  end

  // scaled axis: a_i * sin, later times 2^14 and over len
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        as32_r[i] <= 48'(signed'(dla_r[SQ_BITS-1].a[i])) * 48'(sin_bus[TAY_STEPS].acc);
      end
      c32_r    <= cos_bus[TAY_STEPS].acc;
      len32_r  <= sq_bus[SQ_BITS].root;
      p32_r    <= dla_r[SQ_BITS-1].p;
      zero32_r <= dla_r[SQ_BITS-1].zero;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      as_mag[i] = 44'(as32_r[i][47] ? -as32_r[i] : as32_r[i]);
    end
  end

  // dividend is |a_i * sin| * 2^14; its top 28 bits seed the remainder
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv33_r[i].num  <= {as_mag[i][15:0], 14'b0};
        dv33_r[i].rem  <= {2'b00, as_mag[i][43:16]};
        dv33_r[i].quo  <= '0;
        dv33_r[i].den  <= len32_r;
        pay33_r.neg[i] <= as32_r[i][47];
      end
      pay33_r.c    <= c32_r;
      pay33_r.p    <= p32_r;
      pay33_r.zero <= zero32_r;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign dv_bus[i][0] = dv33_r[i];
    for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
      qaar_div_cell u_div (
        .clk  (clk),
        .en   (en),
        .dv_i (dv_bus[i][k]),
        .dv_o (dv_bus[i][k+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dlb_r[0] <= pay33_r;
      for (int i = 1; i < DIV_BITS; i++) dlb_r[i] <= dlb_r[i-1];
    end
  end

  // q = (u * sin, cos), quotient truncated toward zero
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        q64_r[i] <= dlb_r[DIV_BITS-1].neg[i] ?
                    -signed'({1'b0, dv_bus[i][DIV_BITS].quo}) :
                    signed'({1'b0, dv_bus[i][DIV_BITS].quo});
      end
      q64_r[3] <= 31'(dlb_r[DIV_BITS-1].c);
      p64_r    <= dlb_r[DIV_BITS-1].p;
      zero64_r <= dlb_r[DIV_BITS-1].zero;
    end
  end

  // q*p partial products; p stays in q14, the 2^14 is folded into the rounding
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          m65_r[i][j] <= 47'(q64_r[i]) * 47'(signed'(p64_r[j]));
        end
      end
      q65_r    <= q64_r;
      p65_r    <= p64_r;
      zero65_r <= zero64_r;
    end
  end

  assign o66[0] = 50'(m65_r[1][2]) - 50'(m65_r[2][1]) + 50'(m65_r[3][0]) + 50'(m65_r[0][3]);
  assign o66[1] = 50'(m65_r[2][0]) - 50'(m65_r[0][2]) + 50'(m65_r[3][1]) + 50'(m65_r[1][3]);
  assign o66[2] = 50'(m65_r[0][1]) - 50'(m65_r[1][0]) + 50'(m65_r[3][2]) + 50'(m65_r[2][3]);
  assign o66[3] = 50'(m65_r[3][3]) -
                  (50'(m65_r[0][0]) + 50'(m65_r[1][1]) + 50'(m65_r[2][2]));

  // r = q*p rounded to q28, conj(q) formed alongside
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        r66_r[i] <= 32'((o66[i] + 50'sd8192) >>> 14);
      end
      for (int i = 0; i < 3; i++) qc66_r[i] <= -q65_r[i];
      qc66_r[3] <= q65_r[3];
      p66_r     <= p65_r;
      zero66_r  <= zero65_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          n67_r[i][j] <= 63'(r66_r[i]) * 63'(qc66_r[j]);
        end
      end
      p67_r    <= p66_r;
      zero67_r <= zero66_r;
    end
  end

  assign w_sum[0] = 65'(n67_r[1][2]) - 65'(n67_r[2][1]) + 65'(n67_r[3][0]) + 65'(n67_r[0][3]);
  assign w_sum[1] = 65'(n67_r[2][0]) - 65'(n67_r[0][2]) + 65'(n67_r[3][1]) + 65'(n67_r[1][3]);
  assign w_sum[2] = 65'(n67_r[0][1]) - 65'(n67_r[1][0]) + 65'(n67_r[3][2]) + 65'(n67_r[2][3]);
  assign w_sum[3] = 65'(n67_r[3][3]) -
                    (65'(n67_r[0][0]) + 65'(n67_r[1][1]) + 65'(n67_r[2][2]));

  // round q56 down to q14, saturate to 18 bits, or pass p through for a zero axis
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      w_rnd[i] = 23'((w_sum[i] + 65'sd2199023255552) >>> 42);
      if (zero67_r) begin
        rot_nxt[i] = 18'(signed'(p67_r[i]));
      end else if (w_rnd[i] > 23'sd131071) begin
        rot_nxt[i] = 18'h1FFFF;
      end else if (w_rnd[i] < -23'sd131072) begin
        rot_nxt[i] = 18'h20000;
      end else begin
        rot_nxt[i] = w_rnd[i][17:0];
      end
    end
  end

  // output register splits the pipe from the consumer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en && v_r[NSTG-1]) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v_r[NSTG-1]) begin
      for (int i = 0; i < 4; i++) rot_r[i] <= rot_nxt[i];
      out_zero_r <= zero67_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {8'b0, rot_r};
  assign out_tuser  = out_zero_r;

  // a passed-through point always fits in 16 signed bits
  always_comb begin
    byp_fit = 1'b1;
    for (int i = 0; i < 4; i++) begin
      byp_fit = byp_fit && ((rot_r[i][17:15] == 3'b000) || (rot_r[i][17:15] == 3'b111));
    end
  end

  `QAAR_CHECK_NOW(a_len_nonzero, v_r[SQ_BITS] && !dla_r[SQ_BITS-1].zero, sq_bus[SQ_BITS].root[SQ_BITS-1:14] != '0, "axis length root is below one for a nonzero axis")
  `QAAR_CHECK_NOW(a_quo_range, v_r[SQ_BITS+2+DIV_BITS] && !dlb_r[DIV_BITS-1].zero, (dv_bus[0][DIV_BITS].quo[DIV_BITS-1] == 1'b0) && (dv_bus[1][DIV_BITS].quo[DIV_BITS-1] == 1'b0) && (dv_bus[2][DIV_BITS].quo[DIV_BITS-1] == 1'b0), "unit axis component out of range")
  `QAAR_CHECK_NEXT(a_out_load, en && v_r[NSTG-1], out_tvalid, "finished item did not reach the output register")
  `QAAR_CHECK_NOW(a_bypass_fit, out_tvalid && out_tuser, byp_fit, "zero-axis result is not a sign-extended point")

endmodule

// ===== test/tb_quaternion_axis_angle_rotate.sv =====
module tb_quaternion_axis_angle_rotate;

  // pipe depth of the block in stages; the final drain wait adds a margin on top
  localparam int PIPE_LAT = 67;

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [15:0] az;
    logic signed [15:0] ay;
    logic signed [15:0] ax;
    logic signed [15:0] pw;
    logic signed [15:0] pz;
    logic signed [15:0] py;
    logic signed [15:0] px;
  } rot_req_t;

  typedef struct packed {
    logic        axis_zero;
    logic [17:0] rw;
    logic [17:0] rz;
    logic [17:0] ry;
    logic [17:0] rx;
  } rot_res_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [79:0]  out_tdata;
  logic         out_tuser;

  rot_res_t rotated_q[$];
  int       err_cnt;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       hold_cycles;

  quaternion_axis_angle_rotate i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // floor division by 2^n, works for negative values too
  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint round_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic [17:0] clamp18(longint v);
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v[17:0];
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // hamilton product a*b, components x,y,z,w
  function automatic void ham_mul(input longint a[4], input longint b[4],
                                  output longint o[4]);
    o[0] = a[1]*b[2] - a[2]*b[1] + b[0]*a[3] + a[0]*b[3];
    o[1] = a[2]*b[0] - a[0]*b[2] + b[1]*a[3] + a[1]*b[3];
    o[2] = a[0]*b[1] - a[1]*b[0] + b[2]*a[3] + a[2]*b[3];
    o[3] = a[3]*b[3] - (a[0]*b[0] + a[1]*b[1] + a[2]*b[2]);
  endfunction

  function automatic rot_res_t predict_rotation(rot_req_t rq);
    rot_res_t res;
    longint p[4], q[4], qc[4], r[4], w[4];
    longint a[3];
    longint th, t2, term, s, c, l2, len;
    p = '{rq.px, rq.py, rq.pz, rq.pw};
    a = '{rq.ax, rq.ay, rq.az};
    l2 = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
    if (l2 == 0) begin
      res.rx = clamp18(p[0]);
      res.ry = clamp18(p[1]);
      res.rz = clamp18(p[2]);
      res.rw = clamp18(p[3]);
      res.axis_zero = 1'b1;
      return res;
    end
    // half angle in q28
    th = longint'(rq.angle) * 16384;
    t2 = floor_shr(th * th, 28);
    term = th;
    s = th;
    for (int k = 1; k <= 10; k++) begin
      term = -(floor_shr(term * t2, 28) / longint'((2*k) * (2*k + 1)));
      s += term;
    end
    term = 64'sd1 <<< 28;
    c = term;
    for (int k = 1; k <= 10; k++) begin
      term = -(floor_shr(term * t2, 28) / longint'((2*k - 1) * (2*k)));
      c += term;
    end
    len = int_sqrt(longint'(l2) << 28);
    for (int i = 0; i < 3; i++) begin
      q[i] = (a[i] * 16384 * s) / len;
      qc[i] = -q[i];
    end
    q[3] = c;
    qc[3] = c;
    for (int i = 0; i < 4; i++) p[i] = p[i] * 16384;
    ham_mul(q, p, w);
    for (int i = 0; i < 4; i++) r[i] = round_shift(w[i], 28);
    ham_mul(r, qc, w);
    res.rx = clamp18(round_shift(w[0], 42));
    res.ry = clamp18(round_shift(w[1], 42));
    res.rz = clamp18(round_shift(w[2], 42));
    res.rw = clamp18(round_shift(w[3], 42));
    res.axis_zero = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [17:0] got, logic [17:0] want);
    $display("error: %s got %0h want %0h", what, got, want);
    err_cnt++;
  endtask

  // sends one beat and queues its predicted rotation; valid stays up for the next beat
  task automatic send_rotation(rot_req_t rq);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rq;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rotated_q.push_back(predict_rotation(rq));
  endtask

  function automatic logic signed [15:0] rand_field();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'(signed'($urandom_range(8192)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic rot_req_t rand_req();
    rot_req_t rq;
    rq = $urandom_range(3) == 0 ? {$urandom, $urandom, $urandom, $urandom} : '0;
    if (rq == '0) begin
      rq.px = rand_field(); rq.py = rand_field();
      rq.pz = rand_field(); rq.pw = rand_field();
      rq.ax = rand_field(); rq.ay = rand_field();
      rq.az = rand_field(); rq.angle = rand_field();
    end
    // occasionally a zero axis with random point
    if ($urandom_range(19) == 0) {rq.ax, rq.ay, rq.az} = '0;
    return rq;
  endfunction

  // receiver: stalls at random, or holds off for a counted stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // checker: each result beat against the oldest prediction
  always @(posedge clk) begin
    rot_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (rotated_q.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[17:0], 18'h0);
      end else begin
        want = rotated_q.pop_front();
        if (out_tdata[17:0]  !== want.rx) report_mismatch("rot_x", out_tdata[17:0], want.rx);
        if (out_tdata[35:18] !== want.ry) report_mismatch("rot_y", out_tdata[35:18], want.ry);
        if (out_tdata[53:36] !== want.rz) report_mismatch("rot_z", out_tdata[53:36], want.rz);
        if (out_tdata[71:54] !== want.rw) report_mismatch("rot_w", out_tdata[71:54], want.rw);
        if (out_tdata[79:72] !== 8'h00)
          report_mismatch("pad", 18'(out_tdata[79:72]), 18'h0);
        if (out_tuser !== want.axis_zero)
          report_mismatch("axis_zero", 18'(out_tuser), 18'(want.axis_zero));
      end
    end
  end

  // drops valid and waits for every expected result
  task automatic wait_drained();
    if (in_tvalid) in_tvalid <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
  endtask

  // extremes, zero axis, angles of 0, +-pi, max, axis of each sign
  task automatic test_directed();
    rot_req_t rq;
    logic signed [15:0] ext[4] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh4000};
    logic signed [15:0] ang[6] = '{16'sh0000, 16'sh6488, -16'sh6488,
                                   16'sh7fff, 16'sh8000, 16'sh3244};
    rq = '0; rq.px = 16'sh4000; send_rotation(rq);                  // zero axis
    rq = '1; {rq.ax, rq.ay, rq.az} = '0; send_rotation(rq);         // zero axis, neg p
    for (int i = 0; i < 6; i++) begin
      rq.px = ext[i % 4]; rq.py = ext[(i + 1) % 4];
      rq.pz = ext[(i + 2) % 4]; rq.pw = ext[(i + 3) % 4];
      rq.ax = ext[i % 4]; rq.ay = ext[(i + 3) % 4]; rq.az = 16'sh0001;
      rq.angle = ang[i];
      send_rotation(rq);
    end
    for (int i = 0; i < 6; i++) begin
      rq = '0;
      rq.px = 16'sh7fff; rq.py = 16'sh8000; rq.pz = 16'sh7fff; rq.pw = 16'sh8000;
      rq.ax = i[0] ? 16'sh8000 : 16'sh7fff; rq.ay = rq.ax; rq.az = rq.ax;
      rq.angle = ang[i];
      send_rotation(rq);
    end
    wait_drained();
  endtask

  task automatic test_random(int n, int idle, int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (n) send_rotation(rand_req());
  endtask

  // receiver blocked long enough that the pipe fills and stalls input
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 300;
    repeat (120) send_rotation(rand_req());
    wait_drained();
  endtask

  initial begin
    err_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(250, 0, 0);
    test_random(250, 52, 0);
    wait_drained();
    test_random(250, 0, 52);
    test_random(230, 30, 30);
    test_backpressure();
    recv_stall_pct = 0;
    wait_drained();
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (err_cnt == 0)
      $display("quaternion_axis_angle_rotate: match");
    else
      $display("quaternion_axis_angle_rotate: mismatch");
    $finish;
  end

  initial begin
    #400000;
    $display("quaternion_axis_angle_rotate: mismatch");
    $finish;
  end

endmodule
